// ===== hw/rtl/rrfg_pkg.sv =====
// Shared types and constants for the repeat request flood guard.
// No dependencies; imported by rrfg_ctrl, rrfg_dp and the top level.
`default_nettype none

package rrfg_pkg;

    // Table geometry
    localparam int PEER_SLOTS      = 256;
    localparam int SLOT_W          = $clog2(PEER_SLOTS);
    localparam int PEER_IDX_W      = 8;
    localparam int MAX_STORED_HITS = 7;
    localparam int CNT_W           = $clog2(MAX_STORED_HITS + 1);
    localparam int LIM_W           = 5;

    // Field widths
    localparam int TIME_W     = 48;
    localparam int FP_W       = 64;
    localparam int MAXID_W    = 4;
    localparam int CFG_DATA_W = 32;
    localparam int CFG_IDX_W  = 2;

    // Register reset values
    localparam logic [MAXID_W-1:0]    MAX_IDENTICAL_RST = MAXID_W'(5);
    localparam logic [CFG_DATA_W-1:0] WINDOW_MS_RST     = CFG_DATA_W'(15 * 1000);
    localparam logic [CFG_DATA_W-1:0] BAN_MS_RST        = CFG_DATA_W'(10 * 60 * 1000);

    // Config register indexes; writes to the spare index are dropped
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAX_IDENTICAL = 2'd0,
        CFG_WINDOW_MS     = 2'd1,
        CFG_BAN_MS        = 2'd2,
        CFG_SPARE         = 2'd3
    } cfg_idx_t;

    typedef logic [TIME_W-1:0] ms_t;

    // One peer slot as stored in the record memory
    typedef struct packed {
        logic [FP_W-1:0]                 fp;
        ms_t                             ban_until;
        logic [CNT_W-1:0]                hit_count;
        ms_t [MAX_STORED_HITS-1:0]       hit_times;
    } slot_rec_t;

    localparam int REC_W = $bits(slot_rec_t);

    // Commands from the controller to the datapath
    typedef struct packed {
        logic accept;   // capture input word, launch record read
        logic eval;     // window compares and ban check on the read record
        logic commit;   // write back record, form result
        logic push;     // move result into the output register
    } ctrl_cmd_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rrfg_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module rrfg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                                    aclk,
    input  wire logic                                    wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                        wr_data,
    input  wire logic                                    rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rrfg_ctrl.sv =====
// Sequencing state machine for the flood guard: accept, evaluate, commit, push.
// Depends on rrfg_pkg.
`default_nettype none

module rrfg_ctrl (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    input  wire logic               s_peer_valid,
    output logic                    s_ready,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output rrfg_pkg::ctrl_cmd_t     cmd
);

    import rrfg_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_EVAL   = 4'b0010,
        ST_COMMIT = 4'b0100,
        ST_DONE   = 4'b1000
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = s_peer_valid ? ST_EVAL : ST_DONE;
                end
            end
            ST_EVAL: begin
                cmd.eval   = 1'b1;
                state_next = ST_COMMIT;
            end
            ST_COMMIT: begin
                cmd.commit = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.push   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.push) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/rrfg_dp.sv =====
// Datapath: config registers, slot valid bits, window and ban evaluation,
// record write-back and result registers. Depends on rrfg_pkg.
`default_nettype none

module rrfg_dp (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire rrfg_pkg::ctrl_cmd_t                   cmd,
    input  wire logic                                  cfg_valid,
    input  wire logic [rrfg_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [rrfg_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  wire logic [rrfg_pkg::PEER_IDX_W-1:0]       s_peer_index,
    input  wire logic [rrfg_pkg::FP_W-1:0]             s_request_hash,
    input  wire logic [rrfg_pkg::TIME_W-1:0]           s_now_ms,
    output logic                                       ram_rd_en,
    output logic      [rrfg_pkg::SLOT_W-1:0]           ram_rd_addr,
    input  wire logic [rrfg_pkg::REC_W-1:0]            ram_rd_data,
    output logic                                       ram_wr_en,
    output logic      [rrfg_pkg::SLOT_W-1:0]           ram_wr_addr,
    output logic      [rrfg_pkg::REC_W-1:0]            ram_wr_data,
    output logic                                       m_allowed,
    output logic                                       m_ban_started
);

    import rrfg_pkg::*;

    // Configuration
    logic [MAXID_W-1:0]    cfg_max_reg;
    logic [CFG_DATA_W-1:0] cfg_window_reg;
    logic [CFG_DATA_W-1:0] cfg_ban_reg;

    // Slot valid bits: an unwritten slot reads as all zero
    logic [PEER_SLOTS-1:0] slot_vld_reg;
    logic                  rd_vld_reg;

    // Captured input word
    logic [SLOT_W-1:0] slot_reg;
    logic [FP_W-1:0]   fp_reg;
    ms_t               now_reg;
    logic [SLOT_W-1:0] slot_in;

    // Evaluation results
    slot_rec_t                  rec_in;
    slot_rec_t                  rec_reg;
    logic                       ban_act;
    logic                       ban_act_reg;
    logic [CNT_W-1:0]           cnt0;
    logic [CNT_W-1:0]           cnt0_reg;
    logic [MAX_STORED_HITS-1:0] expired;
    logic [MAX_STORED_HITS-1:0] expired_reg;
    logic [TIME_W:0]            ban_sum;
    ms_t                        ban_end;
    ms_t                        ban_end_reg;

    // Commit
    logic [CNT_W-1:0]          drop;
    logic                      stop;
    logic [CNT_W-1:0]          cnt1;
    logic [LIM_W-1:0]          lim;
    logic                      append;
    ms_t [MAX_STORED_HITS-1:0] new_times;
    slot_rec_t                 new_rec;
    logic                      res_allowed_reg;
    logic                      res_ban_reg;
    logic                      m_allowed_reg;
    logic                      m_ban_reg;

    assign slot_in     = SLOT_W'(s_peer_index % PEER_SLOTS);
    assign ram_rd_en   = cmd.accept;
    assign ram_rd_addr = slot_in;

    // Config writes; indexes beyond the list are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_max_reg    <= MAX_IDENTICAL_RST;
            cfg_window_reg <= WINDOW_MS_RST;
            cfg_ban_reg    <= BAN_MS_RST;
        end else if (cfg_valid) begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_MAX_IDENTICAL: cfg_max_reg    <= cfg_data[MAXID_W-1:0];
                CFG_WINDOW_MS:     cfg_window_reg <= cfg_data;
                CFG_BAN_MS:        cfg_ban_reg    <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Evaluate: ban check, fingerprint match, per-entry window expiry
    always_comb begin
        rec_in  = rd_vld_reg ? slot_rec_t'(ram_rd_data) : '0;
        ban_act = (rec_in.ban_until > now_reg);
        cnt0    = (rec_in.fp == fp_reg) ? rec_in.hit_count : '0;
        for (int k = 0; k < MAX_STORED_HITS; k++) begin
            expired[k] = (CNT_W'(k) < cnt0) &&
                (({1'b0, rec_in.hit_times[k]} + (TIME_W+1)'(cfg_window_reg))
                 < {1'b0, now_reg});
        end
        ban_sum = {1'b0, now_reg} + (TIME_W+1)'(cfg_ban_reg);
        ban_end = ban_sum[TIME_W] ? '1 : ban_sum[TIME_W-1:0];
    end

    // Commit: drop expired prefix, shift, then append, ban or zero count
    always_comb begin
        drop = '0;
        stop = 1'b0;
        for (int k = 0; k < MAX_STORED_HITS; k++) begin
            if (!stop && expired_reg[k]) begin
                drop = CNT_W'(k + 1);
            end else begin
                stop = 1'b1;
            end
        end
        cnt1   = cnt0_reg - drop;
        lim    = (LIM_W'(cfg_max_reg) > LIM_W'(MAX_STORED_HITS + 1)) ?
                 LIM_W'(MAX_STORED_HITS + 1) : LIM_W'(cfg_max_reg);
        append = (LIM_W'(cnt1) + LIM_W'(1)) < lim;

        new_times = rec_reg.hit_times;
        for (int d = 1; d < MAX_STORED_HITS; d++) begin
            for (int j = 0; j < MAX_STORED_HITS - d; j++) begin
                if (drop == CNT_W'(d)) begin
                    new_times[j] = rec_reg.hit_times[j + d];
                end
            end
        end
        for (int j = 0; j < MAX_STORED_HITS; j++) begin
            if (append && (cnt1 == CNT_W'(j))) begin
                new_times[j] = now_reg;
            end
        end

        new_rec = rec_reg;
        if (ban_act_reg) begin
            new_rec.hit_count = '0;
        end else begin
            new_rec.fp        = fp_reg;
            new_rec.hit_times = new_times;
            if (append) begin
                new_rec.ban_until = '0;
                new_rec.hit_count = cnt1 + CNT_W'(1);
            end else begin
                new_rec.ban_until = ban_end_reg;
                new_rec.hit_count = '0;
            end
        end
    end

    assign ram_wr_en   = cmd.commit;
    assign ram_wr_addr = slot_reg;
    assign ram_wr_data = REC_W'(new_rec);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_vld_reg <= '0;
        end else if (cmd.commit) begin
            slot_vld_reg[slot_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            slot_reg        <= slot_in;
            fp_reg          <= s_request_hash;
            now_reg         <= s_now_ms;
            rd_vld_reg      <= slot_vld_reg[slot_in];
            res_allowed_reg <= 1'b1;
            res_ban_reg     <= 1'b0;
        end
        if (cmd.eval) begin
            rec_reg     <= rec_in;
            ban_act_reg <= ban_act;
            cnt0_reg    <= cnt0;
            expired_reg <= expired;
            ban_end_reg <= ban_end;
        end
        if (cmd.commit) begin
            res_allowed_reg <= !ban_act_reg && append;
            res_ban_reg     <= !ban_act_reg && !append;
        end
        if (cmd.push) begin
            m_allowed_reg <= res_allowed_reg;
            m_ban_reg     <= res_ban_reg;
        end
    end

    assign m_allowed     = m_allowed_reg;
    assign m_ban_started = m_ban_reg;

endmodule

`default_nettype wire

// ===== hw/rtl/repeat_request_flood_guard_core.sv =====
// Top level of the repeat request flood guard (per-peer sliding window limiter).
// Depends on rrfg_pkg, rrfg_ram, rrfg_ctrl and rrfg_dp.
//
//   Channel  Ports                                         Word accepted when
//   -------  --------------------------------------------  ------------------
//   input    s_valid s_ready s_peer_valid s_peer_index     s_valid & s_ready
//            s_request_hash s_now_ms
//   result   m_valid m_ready m_allowed m_ban_started       m_valid & m_ready
//   config   cfg_valid cfg_ready cfg_index cfg_data        cfg_valid & cfg_ready
//
// Sequence: an identified request passes record read, evaluate, write back and
//   load output register before the next acceptance; an unidentified one skips
//   evaluate and write back. The order is set by the read-modify-write of the
//   single peer-slot record memory.
// Reset: synchronous, active-low; clears control, config and slot valid bits.
//   No clearing pass: slot valid bits make unwritten slots read as zero.
// Stalls: a result waits in the output register; the next word is taken only
//   once the previous result has moved into it.
`default_nettype none

module repeat_request_flood_guard_core (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // input words
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire logic                                 s_peer_valid,
    input  wire logic [rrfg_pkg::PEER_IDX_W-1:0]      s_peer_index,
    input  wire logic [rrfg_pkg::FP_W-1:0]            s_request_hash,
    input  wire logic [rrfg_pkg::TIME_W-1:0]          s_now_ms,
    // result words
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output logic                                      m_allowed,
    output logic                                      m_ban_started,
    // configuration writes
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [rrfg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [rrfg_pkg::CFG_DATA_W-1:0]      cfg_data
);

    import rrfg_pkg::*;

    ctrl_cmd_t         cmd;
    logic              ram_rd_en;
    logic [SLOT_W-1:0] ram_rd_addr;
    logic [REC_W-1:0]  ram_rd_data;
    logic              ram_wr_en;
    logic [SLOT_W-1:0] ram_wr_addr;
    logic [REC_W-1:0]  ram_wr_data;

    // Config registers take a write every cycle
    assign cfg_ready = 1'b1;

    // Sequence each word: accept -> evaluate -> commit -> push
    rrfg_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_peer_valid (s_peer_valid),
        .s_ready      (s_ready),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .cmd          (cmd)
    );

    // Evaluate the slot record and build the write-back and result
    rrfg_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .s_peer_index   (s_peer_index),
        .s_request_hash (s_request_hash),
        .s_now_ms       (s_now_ms),
        .ram_rd_en      (ram_rd_en),
        .ram_rd_addr    (ram_rd_addr),
        .ram_rd_data    (ram_rd_data),
        .ram_wr_en      (ram_wr_en),
        .ram_wr_addr    (ram_wr_addr),
        .ram_wr_data    (ram_wr_data),
        .m_allowed      (m_allowed),
        .m_ban_started  (m_ban_started)
    );

    // Hold fingerprint, ban end, hit count and hit times for every peer slot
    rrfg_ram #(
        .WIDTH (REC_W),
        .DEPTH (PEER_SLOTS)
    ) u_rec_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/rrfg_checker.sv =====
// Port-level checks for the flood guard, bound to the top level.
// Depends on repeat_request_flood_guard_core.
`default_nettype none

module rrfg_checker (
    input wire logic aclk,
    input wire logic aresetn,
    input wire logic s_valid,
    input wire logic s_ready,
    input wire logic m_valid,
    input wire logic m_ready,
    input wire logic m_allowed,
    input wire logic m_ban_started
);

    logic [1:0] pend_reg, pend_next;
    logic       in_acc, out_acc;

    assign in_acc  = s_valid && s_ready;
    assign out_acc = m_valid && m_ready;

    always_comb begin
        pend_next = pend_reg;
        if (in_acc && !out_acc) begin
            pend_next = pend_reg + 2'd1;
        end else if (!in_acc && out_acc) begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // A stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_allowed) && $stable(m_ban_started))
        else $error("result word changed while stalled");

    // A ban start always refuses the request
    a_ban_refuses: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ban_started |-> !m_allowed)
        else $error("ban started on an allowed request");

    // One word in flight: no acceptance right after an acceptance
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        in_acc |=> !s_ready)
        else $error("input taken while previous word still in work");

    // Results never outnumber accepted words, and at most two are outstanding
    a_no_phantom: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || pend_reg != 2'd0) && pend_reg != 2'd3)
        else $error("result without a matching input word");

endmodule

bind repeat_request_flood_guard_core rrfg_checker u_rrfg_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_allowed     (m_allowed),
    .m_ban_started (m_ban_started)
);

`default_nettype wire
